@@ rtl/chained_glyph_hash_table_assert.svh @@
// -----------------------------------------------------------------------------
// chained glyph hash table assertion macros
// shared property wrappers clocked on clk and disabled during rst
// -----------------------------------------------------------------------------
`ifndef CHAINED_GLYPH_HASH_TABLE_ASSERT_SVH
`define CHAINED_GLYPH_HASH_TABLE_ASSERT_SVH

// condition holds at every edge outside reset
`define CGHT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CGHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CGHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cght_pkg.sv @@
// -----------------------------------------------------------------------------
// cght_pkg
// record layout, operation and status codes for the glyph hash table
// -----------------------------------------------------------------------------
`default_nettype none

package cght_pkg;

  // field widths
  localparam int KEY_W     = 16;
  localparam int POS_W     = 12;
  localparam int SIZE_W    = 8;
  localparam int CNT_W     = 7;
  localparam int FUNC_W    = 1;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // apb
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register map, index is paddr[2]
  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 7'd64;

  // stored glyph record
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } glyph_rec_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_DROPPED  = 2'd1,
    STATUS_HIT      = 2'd2,
    STATUS_MISS     = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ rtl/chained_glyph_hash_table.sv @@
// -----------------------------------------------------------------------------
// chained_glyph_hash_table
// bucketed glyph record table with newest-first insert and lookup
// -----------------------------------------------------------------------------
//  channel    dir  handshake            payload
//  s_axis     in   tvalid/tready        tuser=func, tdata=key,x,y,w,h
//  m_axis     out  tvalid/tready        tuser=status, tdata=x,y,w,h
//  apb        in   psel/penable/pwrite  bucket_count at address 0
//
//  the key modulo runs eight steps, two remainder bits per cycle; a lookup then
//  scans up to BUCKET_DEPTH bucket entries, newest first, each scan step one
//  read of the record memory; a new beat is taken only once the result of the
//  last one is loaded into the output register
//  after reset a clearing pass over all NUM_BUCKETS buckets zeroes the fill
//  counts, s_axis_tready stays low during it
//  a waiting result sits in the output register while the next beat is taken
// -----------------------------------------------------------------------------
`default_nettype none

module chained_glyph_hash_table #(
  parameter int NUM_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cght_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // key, x, y, w, h
  input  logic [cght_pkg::FUNC_W-1:0]         s_axis_tuser,   // func
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cght_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // x, y, w, h
  output logic [cght_pkg::STATUS_W-1:0]       m_axis_tuser,   // status
  // apb
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cght_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cght_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cght_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import cght_pkg::*;

  localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int DMAX_I = (NUM_BUCKETS > 127) ? 127 : NUM_BUCKETS;
  localparam logic [CNT_W-1:0] DMAX = CNT_W'(DMAX_I);
  localparam int DIV_STEPS = KEY_W / 2;
  localparam int DCW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CHK,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t            state;
  logic [BW-1:0]     clr_idx;
  logic [CNT_W-1:0]  bucket_count;

  // captured item
  func_t             func_q;
  glyph_rec_t        in_rec;

  // modulo unit
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem;
  logic [KEY_W-1:0]  key_sh;
  logic [DCW-1:0]    div_cnt;
  logic [CNT_W-1:0]  rem1;
  logic [CNT_W-1:0]  rem2;
  logic [CNT_W-1:0]  div_eff;

  // bucket work
  logic [BW-1:0]     bucket;
  logic [IW-1:0]     scan_idx;
  logic [IW-1:0]     idx_next;
  logic [AW-1:0]     base;
  logic              fill_full;

  // result
  status_t           res_status;
  glyph_rec_t        res_rec;

  // memories
  logic [FW-1:0]     fill_mem [NUM_BUCKETS];
  glyph_rec_t        rec_mem  [SLOTS];
  logic [FW-1:0]     fill_rdata;
  logic [BW-1:0]     fill_raddr;
  logic              fill_we;
  logic [BW-1:0]     fill_waddr;
  logic [FW-1:0]     fill_wdata;
  glyph_rec_t        rec_rdata;
  logic [AW-1:0]     rec_raddr;
  logic              rec_we;
  logic [AW-1:0]     rec_waddr;

  logic              cfg_wr;

  // one restoring step of the remainder
  function automatic logic [CNT_W-1:0] mod_step(input logic [CNT_W-1:0] r,
                                                input logic b,
                                                input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[CNT_W-1:0];
  endfunction

  // divisor clamped to one..min(NUM_BUCKETS, 127)
  always_comb begin
    if (bucket_count == '0) begin
      div_eff = CNT_W'(1);
    end else if (bucket_count > DMAX) begin
      div_eff = DMAX;
    end else begin
      div_eff = bucket_count;
    end
  end

  // two remainder bits per cycle, key msb first
  assign rem1 = mod_step(rem, key_sh[KEY_W-1], div_q);
  assign rem2 = mod_step(rem1, key_sh[KEY_W-2], div_q);

  // addressing
  assign base      = AW'(bucket) * AW'(BUCKET_DEPTH);
  assign fill_full = fill_rdata >= FW'(BUCKET_DEPTH);
  assign idx_next  = (state == ST_CHK) ? IW'(fill_rdata - FW'(1)) : scan_idx - IW'(1);
  assign rec_raddr = base + AW'(idx_next);
  assign rec_waddr = base + AW'(fill_rdata);
  assign fill_raddr = (state == ST_DIV) ? BW'(rem2) : bucket;

  // write ports
  assign rec_we     = (state == ST_CHK) && (func_q == FUNC_INSERT) && !fill_full;
  assign fill_we    = (state == ST_CLEAR) || rec_we;
  assign fill_waddr = (state == ST_CLEAR) ? clr_idx : bucket;
  assign fill_wdata = (state == ST_CLEAR) ? '0 : fill_rdata + FW'(1);

  // fill count memory, registered read
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rdata <= fill_mem[fill_raddr];
  end

  // record memory, registered read
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= in_rec;
    end
    rec_rdata <= rec_mem[rec_raddr];
  end

  // apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ?
                  APB_DATA_W'(bucket_count) : '0;

  assign s_axis_tready = (state == ST_IDLE);

  // control, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      bucket_count  <= BUCKET_COUNT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_BUCKET_COUNT)) begin
        bucket_count <= pwdata[CNT_W-1:0];
      end
      // result state reloads the register itself when the beat leaves
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == BW'(NUM_BUCKETS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func_q   <= func_t'(s_axis_tuser);
            in_rec.key <= s_axis_tdata[15:0];
            in_rec.x   <= s_axis_tdata[27:16];
            in_rec.y   <= s_axis_tdata[39:28];
            in_rec.w   <= s_axis_tdata[47:40];
            in_rec.h   <= s_axis_tdata[55:48];
            key_sh   <= s_axis_tdata[15:0];
            div_q    <= div_eff;
            rem      <= '0;
            div_cnt  <= '0;
            state    <= ST_DIV;
          end
        end

        ST_DIV: begin
          rem     <= rem2;
          key_sh  <= key_sh << 2;
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(DIV_STEPS - 1)) begin
            bucket <= BW'(rem2);
            state  <= ST_CHK;
          end
        end

        // fill count of the bucket is on the memory output
        ST_CHK: begin
          res_rec <= '0;
          if (func_q == FUNC_INSERT) begin
            res_status <= fill_full ? STATUS_DROPPED : STATUS_INSERTED;
            state      <= ST_RESULT;
          end else if (fill_rdata == '0) begin
            res_status <= STATUS_MISS;
            state      <= ST_RESULT;
          end else begin
            scan_idx <= idx_next;
            state    <= ST_SCAN;
          end
        end

        // newest to oldest, one entry per cycle
        ST_SCAN: begin
          if (rec_rdata.key == in_rec.key) begin
            res_status <= STATUS_HIT;
            res_rec    <= rec_rdata;
            state      <= ST_RESULT;
          end else if (scan_idx == '0) begin
            res_status <= STATUS_MISS;
            state      <= ST_RESULT;
          end else begin
            scan_idx <= idx_next;
          end
        end

        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid       <= 1'b1;
            m_axis_tuser        <= res_status;
            m_axis_tdata[11:0]  <= res_rec.x;
            m_axis_tdata[23:12] <= res_rec.y;
            m_axis_tdata[31:24] <= res_rec.w;
            m_axis_tdata[39:32] <= res_rec.h;
            state               <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
`include "chained_glyph_hash_table_assert.svh"

  `CGHT_ASSERT_SAME(a_no_accept_in_clear, state == ST_CLEAR, !s_axis_tready, "beat taken during clear")
  `CGHT_ASSERT_SAME(a_divisor_nonzero, state == ST_DIV, div_q != '0, "zero divisor in modulo")
  `CGHT_ASSERT_SAME(a_scan_in_bucket, state == ST_SCAN, (IW+1)'(scan_idx) < (IW+1)'(BUCKET_DEPTH), "scan index past bucket")
  `CGHT_ASSERT_NEXT(a_result_loaded, state == ST_RESULT && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && state == ST_IDLE, "result not loaded")

endmodule

`default_nettype wire

@@ sim/chained_glyph_hash_table_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// chained_glyph_hash_table_tb
// self-checking bench for the glyph hash table: a directed table of inserts
// and lookups at the reset bucket count, then random phases under several
// bucket counts, with every result beat scored against the row's expected reply or an in-bench model
// -----------------------------------------------------------------------------

module chained_glyph_hash_table_tb;
  import cght_pkg::*;

  localparam int NB          = 64;
  localparam int BD          = 4;
  localparam int DIR_ROWS    = 21;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 150;
  localparam int MAX_SHOWN   = 10;
  localparam logic [APB_ADDR_W-1:0] BUCKET_COUNT_ADDR = {REG_BUCKET_COUNT, 2'b00};

  // one result beat as the table returns it
  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } table_reply_t;

  // one row of the directed table
  typedef struct packed {
    func_t             f;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              typed;
    table_reply_t      want;
  } dir_row_t;

  localparam table_reply_t R_INS  = '{STATUS_INSERTED, 12'h0, 12'h0, 8'h0, 8'h0};
  localparam table_reply_t R_DROP = '{STATUS_DROPPED, 12'h0, 12'h0, 8'h0, 8'h0};
  localparam table_reply_t R_MISS = '{STATUS_MISS, 12'h0, 12'h0, 8'h0, 8'h0};
  localparam table_reply_t R_HIT0 = '{STATUS_HIT, 12'h0, 12'h0, 8'h0, 8'h0};
  localparam table_reply_t R_HITF = '{STATUS_HIT, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF};

  // directed rows, bucket count at its reset value of 64
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{FUNC_LOOKUP, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h00, 1'b1, R_MISS},
    '{FUNC_INSERT, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h00, 1'b1, R_INS},
    '{FUNC_LOOKUP, 16'h0000, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 1'b1, R_HIT0},
    '{FUNC_INSERT, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 1'b1, R_INS},
    '{FUNC_LOOKUP, 16'hFFFF, 12'h000, 12'h000, 8'h00, 8'h00, 1'b1, R_HITF},
    '{FUNC_INSERT, 16'h0040, 12'h123, 12'h456, 8'h78, 8'h9A, 1'b0, R_INS},
    '{FUNC_INSERT, 16'h0080, 12'hABC, 12'hDEF, 8'h12, 8'h34, 1'b0, R_INS},
    // duplicate key, fills bucket zero
    '{FUNC_INSERT, 16'h0000, 12'hF0F, 12'h0F0, 8'h5A, 8'hA5, 1'b0, R_INS},
    '{FUNC_INSERT, 16'h00C0, 12'h111, 12'h222, 8'h33, 8'h44, 1'b1, R_DROP},
    '{FUNC_LOOKUP, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h00, 1'b1,
      '{STATUS_HIT, 12'hF0F, 12'h0F0, 8'h5A, 8'hA5}},
    '{FUNC_LOOKUP, 16'h0040, 12'h000, 12'h000, 8'h00, 8'h00, 1'b0, R_INS},
    '{FUNC_LOOKUP, 16'h00C0, 12'h000, 12'h000, 8'h00, 8'h00, 1'b1, R_MISS},
    // full bucket scanned to the oldest entry
    '{FUNC_LOOKUP, 16'h0100, 12'h000, 12'h000, 8'h00, 8'h00, 1'b1, R_MISS},
    '{FUNC_INSERT, 16'hAAAA, 12'h555, 12'hAAA, 8'h55, 8'hAA, 1'b1, R_INS},
    '{FUNC_LOOKUP, 16'hAAAA, 12'h000, 12'h000, 8'h00, 8'h00, 1'b0, R_INS},
    '{FUNC_INSERT, 16'h5555, 12'hAAA, 12'h555, 8'hAA, 8'h55, 1'b1, R_INS},
    '{FUNC_LOOKUP, 16'h5555, 12'h000, 12'h000, 8'h00, 8'h00, 1'b0, R_INS},
    '{FUNC_LOOKUP, 16'h1555, 12'h000, 12'h000, 8'h00, 8'h00, 1'b1, R_MISS},
    '{FUNC_INSERT, 16'hFFBF, 12'h7FF, 12'h800, 8'h7F, 8'h80, 1'b0, R_INS},
    '{FUNC_LOOKUP, 16'hFFFF, 12'h000, 12'h000, 8'h00, 8'h00, 1'b0, R_INS},
    '{FUNC_LOOKUP, 16'hFFBF, 12'h000, 12'h000, 8'h00, 8'h00, 1'b0, R_INS}
  };

  // bucket counts per random phase, zero and 127 are the clamp cases
  int phase_count [PHASES] = '{37, 127, 0, 64, 1, -1};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // key, x, y, w, h
  logic [FUNC_W-1:0]      s_axis_tuser = '0;   // func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;        // x, y, w, h
  logic [STATUS_W-1:0]    m_axis_tuser;        // status
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // shadow copy of the table
  glyph_rec_t       shadow_rec [NB*BD];
  int               shadow_fill [NB];
  logic [CNT_W-1:0] shadow_count = BUCKET_COUNT_RESET;

  table_reply_t pending_replies [$];
  logic [KEY_W-1:0] key_pool [$];
  table_reply_t exp_reply;
  bit steady = 1'b0;
  int rx_hold = 0;
  int mism_cnt = 0;
  int n_beats = 0, n_ins = 0, n_drop = 0, n_look = 0, n_hit = 0, n_cfg = 0;

  chained_glyph_hash_table u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < NB; i++) shadow_fill[i] = 0;
  end

  // insert or look up in the shadow table, return the reply it implies
  function automatic table_reply_t glyph_table_predict(input func_t f,
      input logic [KEY_W-1:0] key, input logic [POS_W-1:0] gx, gy,
      input logic [SIZE_W-1:0] gw, gh);
    table_reply_t r;
    int d, b, fill, i;
    bit hit;
    r = R_INS;
    hit = 1'b0;
    d = shadow_count;
    if (d == 0) d = 1;
    if (d > NB) d = NB;
    b = int'(key) % d;
    fill = shadow_fill[b];
    if (f == FUNC_INSERT) begin
      n_ins++;
      if (fill >= BD) begin
        r.status = STATUS_DROPPED;
        n_drop++;
      end else begin
        shadow_rec[b*BD + fill] = '{key, gx, gy, gw, gh};
        shadow_fill[b] = fill + 1;
      end
    end else begin
      n_look++;
      i = fill;
      // newest entry first
      while (i > 0 && !hit) begin
        i--;
        if (shadow_rec[b*BD + i].key == key) begin
          hit = 1'b1;
          r = '{STATUS_HIT, shadow_rec[b*BD + i].x, shadow_rec[b*BD + i].y,
                shadow_rec[b*BD + i].w, shadow_rec[b*BD + i].h};
        end
      end
      if (hit) n_hit++;
      else r.status = STATUS_MISS;
    end
    return r;
  endfunction

  function automatic void report_mismatch(input string what, input logic [31:0] want,
      input logic [31:0] got);
    mism_cnt++;
    if (mism_cnt <= MAX_SHOWN)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
  endfunction

  // sender gap: mostly none or short, now and then long
  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one input beat and wait for it to be taken
  task automatic push_item(input func_t f, input logic [KEY_W-1:0] key,
      input logic [POS_W-1:0] gx, gy, input logic [SIZE_W-1:0] gw, gh,
      input logic typed, input table_reply_t want);
    table_reply_t pred;
    int gap;
    pred = glyph_table_predict(f, key, gx, gy, gw, gh);
    pending_replies.push_back(typed ? want : pred);
    s_axis_tuser  <= f;
    s_axis_tdata  <= {gh, gw, gy, gx, key};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [CNT_W-1:0] val);
    logic [APB_DATA_W-CNT_W-1:0] junk;
    junk = (APB_DATA_W-CNT_W)'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BUCKET_COUNT_ADDR;
    pwdata  <= {junk, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    shadow_count = val;
    n_cfg++;
  endtask

  task automatic apb_read_check(input logic [CNT_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BUCKET_COUNT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CNT_W-1:0] !== want)
      report_mismatch("bucket_count readback", 32'(want), 32'(prdata[CNT_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (steady || $urandom_range(0, 99) < 65) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      m_axis_tready <= 1'b0;
    end
  end

  // score each result beat against the oldest pending reply
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_beats++;
      if (pending_replies.size() == 0) begin
        report_mismatch("unrequested result beat", 32'h0, 32'(m_axis_tdata[31:0]));
      end else begin
        exp_reply = pending_replies.pop_front();
        if (m_axis_tuser !== exp_reply.status)
          report_mismatch("status", 32'(exp_reply.status), 32'(m_axis_tuser));
        if (m_axis_tdata[11:0] !== exp_reply.x)
          report_mismatch("found_x", 32'(exp_reply.x), 32'(m_axis_tdata[11:0]));
        if (m_axis_tdata[23:12] !== exp_reply.y)
          report_mismatch("found_y", 32'(exp_reply.y), 32'(m_axis_tdata[23:12]));
        if (m_axis_tdata[31:24] !== exp_reply.w)
          report_mismatch("found_w", 32'(exp_reply.w), 32'(m_axis_tdata[31:24]));
        if (m_axis_tdata[39:32] !== exp_reply.h)
          report_mismatch("found_h", 32'(exp_reply.h), 32'(m_axis_tdata[39:32]));
      end
    end
  end

  // main sequence
  initial begin
    func_t f;
    logic [KEY_W-1:0] key;
    int r, cnt;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read_check(BUCKET_COUNT_RESET);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      push_item(dir_rows[i].f, dir_rows[i].key, dir_rows[i].x, dir_rows[i].y,
                dir_rows[i].w, dir_rows[i].h, dir_rows[i].typed, dir_rows[i].want);

    // random phases, one bucket count each
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (16) @(posedge clk);
      cnt = (phase_count[p] < 0) ? $urandom_range(2, 126) : phase_count[p];
      apb_write(CNT_W'(cnt));
      apb_read_check(CNT_W'(cnt));
      steady = (p == 3);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        f = ($urandom_range(0, 99) < 45) ? FUNC_INSERT : FUNC_LOOKUP;
        r = $urandom_range(0, 99);
        if (key_pool.size() > 0 && r < 60)
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 85)
          key = KEY_W'($urandom_range(0, 255));
        else
          key = KEY_W'($urandom);
        if (f == FUNC_INSERT) begin
          key_pool.push_back(key);
          if (key_pool.size() > 32) void'(key_pool.pop_front());
        end
        push_item(f, key, POS_W'($urandom), POS_W'($urandom), SIZE_W'($urandom),
                  SIZE_W'($urandom), 1'b0, R_INS);
        // hold off now and then until the table has answered everything
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("run covered %0d inserts (%0d dropped) and %0d lookups (%0d hits), %0d beats",
             n_ins, n_drop, n_look, n_hit, n_beats);
    $display("bucket count written %0d times, including 0, 1, 64 and 127", n_cfg);
    if (mism_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mism_cnt);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
